### hw/rtl/pmhf_pkg.sv
// Shared types and constants for the packed monochrome span fill core.
// No dependencies; imported by packed_mono_hline_fill_core.
package pmhf_pkg;

    // Row base plus byte offset: at most row 255 times 63 bytes, plus 31.
    localparam int FULL_AW = 14;

    localparam logic [5:0] ROW_BYTES_RESET = 6'd4;
    localparam logic [7:0] FULL_BYTE       = 8'hFF;

    typedef logic [7:0]         byte_t;
    typedef logic [FULL_AW-1:0] full_addr_t;

    // One byte whose read is in flight; its write-back follows in the next cycle,
    // and its result is registered from that write-back.
    typedef struct packed {
        logic       valid;
        full_addr_t addr;
        byte_t      mask;
        logic       last;
    } pend_t;

    function automatic byte_t head_mask(input logic [2:0] bit_pos);
        head_mask = FULL_BYTE >> bit_pos;
    endfunction

    function automatic byte_t tail_mask(input logic [2:0] bit_pos);
        tail_mask = FULL_BYTE << (3'd7 - bit_pos);
    endfunction

endpackage

### hw/rtl/packed_mono_hline_fill_core.sv
// Packed 1-bit-per-pixel framebuffer with horizontal span fill.
// Results: for a span of n bytes, results arrive one per cycle, each registered
// from its byte's write-back; busy stays high through CALC, RUN and DRAIN.
// An out-of-range request answers with one error result, registered in CALC.
// Throughput is bound by the memory: one read-modify-write per byte.
// Reset starts a clearing pass over all FB_BYTES bytes, one byte per cycle, with
// busy high; the receiver cannot stall results. Depends on pmhf_pkg.
module packed_mono_hline_fill_core
    import pmhf_pkg::*;
#(
    parameter int FB_BYTES      = 256,
    parameter int MAX_ROW_BYTES = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] x_start,
    input  logic [7:0] x_end,
    input  logic [7:0] row,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data,
    output logic       result_strobe,
    output logic [7:0] byte_addr,
    output logic [7:0] byte_value,
    output logic       out_of_range,
    output logic       last
);

    localparam int              AW       = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;
    localparam logic [AW-1:0]   LAST_IDX = AW'(FB_BYTES - 1);
    localparam logic [16:0]     FB_LIM   = 17'(FB_BYTES);
    localparam logic [6:0]      MAX_RB   = 7'(MAX_ROW_BYTES);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [5:0]    row_bytes_reg;
    logic [7:0]    xs_reg, xs_next;
    logic [7:0]    xe_reg, xe_next;
    logic [7:0]    row_reg, row_next;
    logic [5:0]    w_reg, w_next;
    full_addr_t    base_reg, base_next;
    logic [4:0]    b_reg, b_next;
    pend_t         pend_reg, pend_next;
    byte_t         rdata_reg;

    logic          strobe_reg, strobe_next;
    logic [7:0]    addr_out_reg, addr_out_next;
    byte_t         value_out_reg, value_out_next;
    logic          oor_reg, oor_next;
    logic          last_reg, last_next;

    byte_t         mem [FB_BYTES];

    logic [5:0]    w_clamp;
    logic [8:0]    row_plus;
    logic [14:0]   lim_prod;
    full_addr_t    base_prod;
    logic          calc_err;
    full_addr_t    rd_full;
    byte_t         run_mask;
    logic          run_last;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    byte_t         mem_wdata;
    byte_t         merged;

    assign busy          = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_strobe = strobe_reg;
    assign byte_addr     = addr_out_reg;
    assign byte_value    = value_out_reg;
    assign out_of_range  = oor_reg;
    assign last          = last_reg;

    // A width above the supported maximum is used as the maximum.
    assign w_clamp = ({1'b0, row_bytes_reg} > MAX_RB) ? MAX_RB[5:0] : row_bytes_reg;

    // row >= FB_BYTES / w is the same test as (row + 1) * w > FB_BYTES.
    assign row_plus  = {1'b0, row_reg} + 9'd1;
    assign lim_prod  = 15'(row_plus) * 15'(w_reg);
    assign base_prod = FULL_AW'(row_reg) * FULL_AW'(w_reg);
    assign calc_err  = (w_reg == 6'd0) || ({2'b00, lim_prod} > FB_LIM)
                    || ({1'b0, xe_reg} >= {w_reg, 3'b000});

    assign rd_full  = base_reg + FULL_AW'(b_reg);
    assign run_last = (b_reg == xe_reg[7:3]);

    always_comb
    begin
        run_mask = FULL_BYTE;
        if (b_reg == xs_reg[7:3])
        begin
            run_mask = run_mask & head_mask(xs_reg[2:0]);
        end
        if (run_last)
        begin
            run_mask = run_mask & tail_mask(xe_reg[2:0]);
        end
    end

    assign merged = rdata_reg | pend_reg.mask;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = AW'(pend_reg.addr);
        mem_wdata = merged;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = 8'h00;
        end
        else if (pend_reg.valid)
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        xs_next        = xs_reg;
        xe_next        = xe_reg;
        row_next       = row_reg;
        w_next         = w_reg;
        base_next      = base_reg;
        b_next         = b_reg;
        pend_next      = '0;
        strobe_next    = 1'b0;
        addr_out_next  = addr_out_reg;
        value_out_next = value_out_reg;
        oor_next       = oor_reg;
        last_next      = last_reg;

        if (pend_reg.valid)
        begin
            strobe_next    = 1'b1;
            addr_out_next  = pend_reg.addr[7:0];
            value_out_next = merged;
            oor_next       = 1'b0;
            last_next      = pend_reg.last;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    // Swapped columns are put in order here.
                    xs_next    = (x_start > x_end) ? x_end : x_start;
                    xe_next    = (x_start > x_end) ? x_start : x_end;
                    row_next   = row;
                    w_next     = w_clamp;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                base_next = base_prod;
                b_next    = xs_reg[7:3];
                if (calc_err)
                begin
                    strobe_next    = 1'b1;
                    addr_out_next  = 8'h00;
                    value_out_next = 8'h00;
                    oor_next       = 1'b1;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                pend_next.valid = 1'b1;
                pend_next.addr  = rd_full;
                pend_next.mask  = run_mask;
                pend_next.last  = run_last;
                b_next          = b_reg + 5'd1;
                if (run_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Reads of the next byte overlap the write-back of the previous one; within
    // one request the two addresses always differ.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[AW'(rd_full)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            row_bytes_reg <= ROW_BYTES_RESET;
            pend_reg      <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            pend_reg   <= pend_next;
            strobe_reg <= strobe_next;
            if (cfg_valid && cfg_ready)
            begin
                row_bytes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        xs_reg        <= xs_next;
        xe_reg        <= xe_next;
        row_reg       <= row_next;
        w_reg         <= w_next;
        base_reg      <= base_next;
        b_reg         <= b_next;
        addr_out_reg  <= addr_out_next;
        value_out_reg <= value_out_next;
        oor_reg       <= oor_next;
        last_reg      <= last_next;
    end

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !pend_reg.valid)
        else $error("pending write-back while idle");

    a_clear_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !pend_reg.valid)
        else $error("pending write-back during clearing pass");

    a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_CALC))
        else $error("accepted request did not enter calculation");

    a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last) |=> result_strobe)
        else $error("gap inside a result burst");

    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && out_of_range) |->
            (last && byte_addr == 8'h00 && byte_value == 8'h00))
        else $error("malformed error result");

endmodule
